### sv/gf16c_pkg.sv
// gf16c_pkg: types, register indexes and helper functions for the gf(2^16)
// constant multiply-accumulate unit; no dependencies
package gf16c_pkg;

   localparam int WORD_W    = 16;
   localparam int MAX_LANES = 4;
   localparam int HALF_W    = WORD_W / 2;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COEFFICIENT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACCUMULATE_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REDUCTION_POLY  = 2'd2;

   localparam logic [WORD_W-1:0] COEFFICIENT_RESET = 16'h0001;
   localparam logic [WORD_W-1:0] POLY_RESET        = 16'h100B;

   typedef logic [WORD_W-1:0][WORD_W-1:0] columns_type;
   typedef logic [HALF_W-1:0][WORD_W-1:0] half_columns_type;

   typedef struct packed {
      logic [63:0] src_lanes;
      logic [63:0] acc_lanes;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [63:0] out_lanes;
      logic        last_out;
   } rsp_type;

   // request to rebuild the multiply columns from a new seed
   typedef struct packed {
      logic              load;
      logic [WORD_W-1:0] seed;
   } col_load_type;

   // multiply by x modulo x^16 + poly
   function automatic logic [WORD_W-1:0] times_x(input logic [WORD_W-1:0] v,
                                                 input logic [WORD_W-1:0] poly);
      logic [WORD_W-1:0] r;
      r = {v[WORD_W-2:0], 1'b0};
      if (v[WORD_W-1]) begin
         r = r ^ poly;
      end
      return r;
   endfunction

   // xor of the columns selected by eight source bits
   function automatic logic [WORD_W-1:0] xor_columns(input logic [HALF_W-1:0] bits,
                                                     input half_columns_type cols);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < HALF_W; i++) begin
         if (bits[i]) begin
            r = r ^ cols[i];
         end
      end
      return r;
   endfunction

endpackage

### sv/gf16c_column_gen.sv
// gf16c_column_gen: sequencer that derives coefficient times x^i, one column
// per cycle, after a coefficient or polynomial write; uses gf16c_pkg
module gf16c_column_gen
   import gf16c_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  col_load_type      load_req,
   input  logic [WORD_W-1:0] poly,
   output columns_type       columns,
   output logic              busy
);

   localparam int CNT_W = $clog2(WORD_W);

   logic              running_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WORD_W-1:0] value_ff;
   columns_type       columns_ff;

   // one column per cycle; reset columns are x^i for coefficient one
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         cnt_ff     <= '0;
         value_ff   <= '0;
         for (int i = 0; i < WORD_W; i++) begin
            columns_ff[i] <= WORD_W'(1) << i;
         end
      end else if (load_req.load) begin
         running_ff <= 1'b1;
         cnt_ff     <= '0;
         value_ff   <= load_req.seed;
      end else if (running_ff) begin
         columns_ff[cnt_ff] <= value_ff;
         value_ff           <= times_x(value_ff, poly);
         cnt_ff             <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            running_ff <= 1'b0;
         end
      end
   end

   assign columns = columns_ff;
   assign busy    = running_ff;

endmodule

### sv/gf16c_lane_mul.sv
// gf16c_lane_mul: two-stage xor matrix product of one 16-bit word with the
// multiply columns, with optional accumulate; uses gf16c_pkg
module gf16c_lane_mul
   import gf16c_pkg::*;
(
   input  logic              clock,
   input  columns_type       columns,
   input  logic [WORD_W-1:0] src_word,
   input  logic [WORD_W-1:0] acc_word,
   input  logic              acc_mode,
   output logic [WORD_W-1:0] out_word
);

   logic [WORD_W-1:0] lo_ff;
   logic [WORD_W-1:0] hi_ff;
   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] out_ff;
   logic [WORD_W-1:0] out_in;
   half_columns_type  lo_cols;
   half_columns_type  hi_cols;

   assign lo_cols = columns[HALF_W-1:0];
   assign hi_cols = columns[WORD_W-1:HALF_W];

   // partial products over the low and high source bytes
   always_ff @(posedge clock) begin
      lo_ff  <= xor_columns(src_word[HALF_W-1:0], lo_cols);
      hi_ff  <= xor_columns(src_word[WORD_W-1:HALF_W], hi_cols);
      acc_ff <= acc_word;
   end

   // combine halves and fold in the accumulator
   always_comb begin
      out_in = lo_ff ^ hi_ff;
      if (acc_mode) begin
         out_in = out_in ^ acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_word = out_ff;

endmodule

### sv/gf16_constant_multiply_accumulate_unit.sv
// gf16_constant_multiply_accumulate_unit: top level, config registers, column
// sequencer and per-lane multiply pipeline; uses gf16c_pkg, gf16c_column_gen,
// gf16c_lane_mul
//
//   channel   ports                         handshake
//   -------   ---------------------------   ------------------------------
//   request   start, busy, req_item         taken when start & !busy
//   result    rsp_valid, rsp_item           one-cycle strobe, never held
//   config    csr_we, csr_index, csr_wdata  written when csr_we is high
//
// one item per cycle while busy is low; a taken item passes the input register,
// the byte partial products and the combine and accumulate register to its result.
// a write to coefficient or reduction_poly holds busy while the column
// sequencer derives the sixteen columns, one per cycle.
// reset is synchronous; the columns come out of reset already valid.
// the receiver cannot stall, so the pipeline never holds.
module gf16_constant_multiply_accumulate_unit
   import gf16c_pkg::*;
#(
   parameter int LANES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_valid,
   output rsp_type              rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic [WORD_W-1:0] coef_ff;
   logic              mode_ff;
   logic [WORD_W-1:0] poly_ff;
   logic              coef_wr;
   logic              poly_wr;
   col_load_type      load_req;
   columns_type       columns;
   logic              gen_busy;
   logic              accept;

   logic              s1_valid_ff;
   req_type           s1_item_ff;
   logic              s2_valid_ff;
   logic              s2_last_ff;
   logic              s3_valid_ff;
   logic              s3_last_ff;
   logic [MAX_LANES-1:0][WORD_W-1:0] lane_out;

   // configuration registers
   assign coef_wr = csr_we && (csr_index == REG_COEFFICIENT);
   assign poly_wr = csr_we && (csr_index == REG_REDUCTION_POLY);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEFFICIENT_RESET;
         mode_ff <= 1'b0;
         poly_ff <= POLY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_COEFFICIENT:     coef_ff <= csr_wdata;
            REG_ACCUMULATE_MODE: mode_ff <= csr_wdata[0];
            REG_REDUCTION_POLY:  poly_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // column refresh on coefficient or polynomial change
   assign load_req.load = coef_wr || poly_wr;
   assign load_req.seed = coef_wr ? csr_wdata : coef_ff;

   gf16c_column_gen u_column_gen (
      .clock    (clock),
      .reset    (reset),
      .load_req (load_req),
      .poly     (poly_ff),
      .columns  (columns),
      .busy     (gen_busy)
   );

   assign busy   = load_req.load || gen_busy;
   assign accept = start && !busy;

   // valid and last travel beside the lane data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= req_item;
      s2_last_ff <= s1_item_ff.last_in;
      s3_last_ff <= s2_last_ff;
   end

   // one multiplier per active lane, unused lanes read zero
   for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
      if (g < LANES) begin : g_active
         gf16c_lane_mul u_lane_mul (
            .clock    (clock),
            .columns  (columns),
            .src_word (s1_item_ff.src_lanes[g*WORD_W +: WORD_W]),
            .acc_word (s1_item_ff.acc_lanes[g*WORD_W +: WORD_W]),
            .acc_mode (mode_ff),
            .out_word (lane_out[g])
         );
      end else begin : g_unused
         assign lane_out[g] = '0;
      end
   end

   assign rsp_valid          = s3_valid_ff;
   assign rsp_item.out_lanes = lane_out;
   assign rsp_item.last_out  = s3_last_ff;

endmodule

### dv/testbench.sv
// testbench for gf16_constant_multiply_accumulate_unit: directed and random items
// checked against a local gf(2^16) column predictor; depends on gf16c_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
   import gf16c_pkg::*;

   localparam int NUM_LANES = 4;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 120;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_item = '0;
   logic                 rsp_valid;
   rsp_type              rsp_item;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   // predictor copy of the configuration and the multiply columns
   logic [WORD_W-1:0] coef_reg;
   logic [WORD_W-1:0] poly_reg;
   logic              acc_mode;
   logic [WORD_W-1:0] gf_cols [WORD_W];

   req_type src_queue[$];
   rsp_type product_queue[$];
   int      sender_idle_pct = 20;
   int      mismatch_count = 0;
   int      cycle_count = 0;

   gf16_constant_multiply_accumulate_unit #(
      .LANES(NUM_LANES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // coefficient times x^i, reduced by the current polynomial
   function automatic void refresh_columns();
      logic [WORD_W-1:0] v;
      v = coef_reg;
      for (int i = 0; i < WORD_W; i++) begin
         gf_cols[i] = v;
         if (v[WORD_W-1]) begin
            v = {v[WORD_W-2:0], 1'b0} ^ poly_reg;
         end else begin
            v = {v[WORD_W-2:0], 1'b0};
         end
      end
   endfunction

   function automatic logic [WORD_W-1:0] gf_scale(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (w[i]) begin
            r = r ^ gf_cols[i];
         end
      end
      return r;
   endfunction

   function automatic rsp_type predict_result(input req_type item);
      rsp_type           r;
      logic [WORD_W-1:0] p;
      r = '0;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         p = gf_scale(item.src_lanes[lane*WORD_W +: WORD_W]);
         if (acc_mode) begin
            p = p ^ item.acc_lanes[lane*WORD_W +: WORD_W];
         end
         r.out_lanes[lane*WORD_W +: WORD_W] = p;
      end
      r.last_out = item.last_in;
      return r;
   endfunction

   // biased word: zero, all ones, one bit, or anything
   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(5))
         0: w = '0;
         1: w = '1;
         2: w = 16'h0001 << $urandom_range(WORD_W - 1);
         default: w = 16'($urandom);
      endcase
      return w;
   endfunction

   function automatic req_type random_item();
      req_type it;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         it.src_lanes[lane*WORD_W +: WORD_W] = pick_word();
      end
      it.acc_lanes = {$urandom, $urandom};
      it.last_in   = 1'($urandom_range(1));
      return it;
   endfunction

   task automatic queue_item(input logic [63:0] src, input logic [63:0] acc,
                             input logic last);
      req_type it;
      it.src_lanes = src;
      it.acc_lanes = acc;
      it.last_in   = last;
      src_queue.push_back(it);
   endtask

   // block idle: nothing to send, nothing in flight
   task automatic wait_drained();
      while (src_queue.size() != 0 || start || product_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // register write, then let any column refresh finish
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_COEFFICIENT: begin
            coef_reg = data;
            refresh_columns();
         end
         REG_ACCUMULATE_MODE: begin
            acc_mode = data[0];
         end
         REG_REDUCTION_POLY: begin
            poly_reg = data;
            refresh_columns();
         end
         default: begin
         end
      endcase
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic random_setup();
      logic [WORD_W-1:0] poly;
      if ($urandom_range(1)) begin
         poly = ($urandom_range(2) == 0) ? 16'($urandom) : POLY_RESET;
         write_reg(REG_REDUCTION_POLY, poly);
      end
      write_reg(REG_COEFFICIENT, pick_word());
      if ($urandom_range(1)) begin
         write_reg(REG_ACCUMULATE_MODE, 16'($urandom));
      end
      if ($urandom_range(3) == 0) begin
         write_reg(REG_UNUSED, 16'($urandom));
      end
   endtask

   // driver: present the next item, hold it while busy
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            product_queue.push_back(predict_result(req_item));
         end
         if (!start || !busy) begin
            if (src_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               start    <= 1'b1;
               req_item <= src_queue.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: each result against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (product_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected item: out_lanes %h last_out %b",
                        rsp_item.out_lanes, rsp_item.last_out);
            end
         end else begin
            want = product_queue.pop_front();
            if (rsp_item.out_lanes !== want.out_lanes ||
                rsp_item.last_out !== want.last_out) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch: out_lanes exp %h got %h, last_out exp %b got %b",
                           want.out_lanes, rsp_item.out_lanes,
                           want.last_out, rsp_item.last_out);
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      coef_reg = COEFFICIENT_RESET;
      acc_mode = 1'b0;
      poly_reg = POLY_RESET;
      refresh_columns();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset columns, accumulator ignored in multiply mode
      queue_item(64'h0, 64'h0, 1'b0);
      queue_item('1, '1, 1'b1);
      queue_item({4{16'h8000}}, 64'h0, 1'b0);
      queue_item({4{16'h0001}}, '1, 1'b1);
      queue_item(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
      wait_drained();

      // largest coefficient, accumulate on with all upper data bits set
      write_reg(REG_COEFFICIENT, 16'hffff);
      write_reg(REG_ACCUMULATE_MODE, 16'hffff);
      queue_item('1, 64'h0, 1'b0);
      queue_item('1, '1, 1'b1);
      queue_item(64'h8000_4000_0002_0001, 64'haaaa_5555_aaaa_5555, 1'b0);
      queue_item(64'h0, '1, 1'b1);
      wait_drained();

      // polynomial write alone must refresh the columns
      write_reg(REG_REDUCTION_POLY, 16'hffff);
      queue_item('1, '1, 1'b0);
      src_queue.push_back(random_item());
      wait_drained();

      // zero coefficient passes the accumulator straight through
      write_reg(REG_COEFFICIENT, 16'h0000);
      queue_item('1, 64'h5555_aaaa_5555_aaaa, 1'b1);
      queue_item('1, 64'h0, 1'b0);
      wait_drained();

      // zero polynomial (reducible), top-bit coefficient, multiply mode
      write_reg(REG_ACCUMULATE_MODE, 16'hfffe);
      write_reg(REG_REDUCTION_POLY, 16'h0000);
      write_reg(REG_COEFFICIENT, 16'h8000);
      queue_item('1, '1, 1'b0);
      queue_item({4{16'h8000}}, 64'h0, 1'b1);
      wait_drained();

      // write to an unused index changes nothing
      write_reg(REG_UNUSED, 16'hffff);
      queue_item('1, '1, 1'b1);
      src_queue.push_back(random_item());
      wait_drained();

      // random phases, sender gaps at 20, then 69, then none
      for (int ph = 0; ph < PHASES; ph++) begin
         sender_idle_pct = (ph < PHASES / 3) ? 20 : (ph < 2 * PHASES / 3) ? 69 : 0;
         wait_drained();
         random_setup();
         repeat (PHASE_ITEMS) src_queue.push_back(random_item());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
sv/gf16c_pkg.sv
sv/gf16c_column_gen.sv
sv/gf16c_lane_mul.sv
sv/gf16_constant_multiply_accumulate_unit.sv
dv/testbench.sv
